FILE: rtl/nwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nwc_pkg
// Shared types, codes and helpers for the normalized window convolution.
// ---------------------------------------------------------------------------
package nwc_pkg;

	localparam int MAX_EXTENT = 7;
	localparam int TAP_SIDE   = 2 * MAX_EXTENT + 1;
	localparam int TAP_DEPTH  = TAP_SIDE * TAP_SIDE;
	localparam int TAP_AW     = 8;
	localparam int FRAME_AW   = 16;
	localparam int PLANES     = 4;
	localparam int ACC_W      = 36;
	localparam int REM_W      = ACC_W - 8;

	localparam logic [1:0] OP_LOAD_TAP = 2'd0;
	localparam logic [1:0] OP_STORE    = 2'd1;
	localparam logic [1:0] OP_COMPUTE  = 2'd2;

	localparam logic [2:0] CFG_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_LEFT   = 3'd2;
	localparam logic [2:0] CFG_TOP    = 3'd3;
	localparam logic [2:0] CFG_RIGHT  = 3'd4;
	localparam logic [2:0] CFG_BOTTOM = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_SAT,
		ST_DIV,
		ST_FIN
	} nwc_state_t;

	typedef struct packed {
		logic       wr_tap;
		logic       wr_pix;
		logic       start;
		logic       issue;
		logic [3:0] row;
		logic [3:0] col;
		logic [7:0] tap_idx;
		logic       div_init;
		logic       div_step;
		logic [2:0] div_bit;
		logic       load_out;
	} nwc_cmd_t;

	typedef struct packed {
		logic [2:0] ext_l;
		logic [2:0] ext_t;
		logic [2:0] ext_r;
		logic [2:0] ext_b;
		logic       out_free;
	} nwc_stat_t;

	// Mirror without repeating the edge, then clamp into 0..n-1.
	function automatic logic [7:0] mirror(input logic signed [10:0] c,
			input logic [8:0] n);
		logic signed [10:0] v;
		logic signed [10:0] lim;
		v   = c;
		lim = $signed({2'b00, n}) - 11'sd1;
		if (v < 0)
			v = -v;
		if (v > lim)
			v = (lim <<< 1) - v;
		if (v < 0)
			v = 11'sd0;
		if (v > lim)
			v = lim;
		return v[7:0];
	endfunction

	function automatic logic [8:0] clamp_size(input logic [8:0] s);
		if (s == 9'd0)
			return 9'd1;
		else if (s > 9'd256)
			return 9'd256;
		else
			return s;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/nwc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nwc channel interfaces
// Request, result and register write channels, valid/ready.
// ---------------------------------------------------------------------------
interface nwc_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [7:0]         pos_x;
	logic [7:0]         pos_y;
	logic [7:0]         tap_index;
	logic signed [17:0] tap_value;
	logic [7:0]         in_chan0;
	logic [7:0]         in_chan1;
	logic [7:0]         in_chan2;
	logic [7:0]         in_chan3;
	modport source (output valid, operation, pos_x, pos_y, tap_index, tap_value,
		in_chan0, in_chan1, in_chan2, in_chan3, input ready);
	modport sink (input valid, operation, pos_x, pos_y, tap_index, tap_value,
		in_chan0, in_chan1, in_chan2, in_chan3, output ready);
endinterface

interface nwc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_x;
	logic [7:0] out_y;
	logic [7:0] out_chan0;
	logic [7:0] out_chan1;
	logic [7:0] out_chan2;
	logic [7:0] out_chan3;
	modport source (output valid, out_x, out_y, out_chan0, out_chan1, out_chan2,
		out_chan3, input ready);
	modport sink (input valid, out_x, out_y, out_chan0, out_chan1, out_chan2,
		out_chan3, output ready);
endinterface

interface nwc_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [8:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/nwc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nwc_ctrl
// Sequencer: load and store decode, window walk, divide steps and result hand-off.
// ---------------------------------------------------------------------------
module nwc_ctrl
	import nwc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [1:0] req_op,
	output logic            req_ready,
	input  wire nwc_stat_t  stat,
	output nwc_cmd_t        cmd
);

	nwc_state_t state_q, state_d;
	logic [3:0] row_q, col_q;
	logic [7:0] tap_q;
	logic [2:0] bit_q;
	logic [3:0] row_last, col_last;

	assign row_last = {1'b0, stat.ext_t} + {1'b0, stat.ext_b};
	assign col_last = {1'b0, stat.ext_l} + {1'b0, stat.ext_r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			tap_q <= '0;
			bit_q <= '0;
		end else begin
			if (cmd.start) begin
				row_q <= '0;
				col_q <= '0;
				tap_q <= '0;
			end else if (cmd.issue) begin
				tap_q <= tap_q + 8'd1;
				if (col_q == col_last) begin
					col_q <= '0;
					row_q <= row_q + 4'd1;
				end else begin
					col_q <= col_q + 4'd1;
				end
			end
			if (cmd.div_init)
				bit_q <= 3'd7;
			else if (cmd.div_step)
				bit_q <= bit_q - 3'd1;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		cmd          = '0;
		cmd.row      = row_q;
		cmd.col      = col_q;
		cmd.tap_idx  = tap_q;
		cmd.div_bit  = bit_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (req_op)
						OP_LOAD_TAP: cmd.wr_tap = 1'b1;
						OP_STORE:    cmd.wr_pix = 1'b1;
						OP_COMPUTE: begin
							cmd.start = 1'b1;
							state_d   = ST_WALK;
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				cmd.issue = 1'b1;
				if (row_q == row_last && col_q == col_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_SAT;
			ST_SAT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (bit_q == 3'd0)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/nwc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nwc_dp
// Registers, tap and frame stores, four MAC lanes, bit-serial dividers.
// ---------------------------------------------------------------------------
module nwc_dp
	import nwc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	nwc_req_if.sink    req,
	nwc_rsp_if.source  rsp,
	nwc_cfg_if.sink    cfg,
	input  wire nwc_cmd_t cmd,
	output nwc_stat_t  stat
);

	logic [8:0] width_q, height_q;
	logic [2:0] ext_l_q, ext_t_q, ext_r_q, ext_b_q;

	logic signed [17:0] tap_mem [TAP_DEPTH];
	logic [31:0]        frame_mem [2**FRAME_AW];

	logic [7:0] pos_x_q, pos_y_q;
	logic [8:0] w_eff, h_eff;
	logic [7:0] sx, sy;
	logic [3:0] tap_w, tap_h;
	logic [7:0] n_taps;
	logic [15:0] sat_thr;

	logic               issue_s1;
	logic [31:0]        pix_s1;
	logic signed [17:0] tap_s1;

	logic signed [ACC_W-1:0] acc_q [PLANES];
	logic [REM_W-1:0]        rem_q [PLANES];
	logic [7:0]              quo_q [PLANES];

	logic       out_valid_q;
	logic [7:0] out_x_q, out_y_q;
	logic [7:0] out_c_q [PLANES];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			ext_l_q  <= 3'd2;
			ext_t_q  <= 3'd2;
			ext_r_q  <= 3'd2;
			ext_b_q  <= 3'd2;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_WIDTH:  width_q  <= cfg.data;
				CFG_HEIGHT: height_q <= cfg.data;
				CFG_LEFT:   ext_l_q  <= cfg.data[2:0];
				CFG_TOP:    ext_t_q  <= cfg.data[2:0];
				CFG_RIGHT:  ext_r_q  <= cfg.data[2:0];
				CFG_BOTTOM: ext_b_q  <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	assign w_eff   = clamp_size(width_q);
	assign h_eff   = clamp_size(height_q);
	assign tap_w   = {1'b0, ext_l_q} + {1'b0, ext_r_q} + 4'd1;
	assign tap_h   = {1'b0, ext_t_q} + {1'b0, ext_b_q} + 4'd1;
	assign n_taps  = {4'd0, tap_w} * {4'd0, tap_h};
	assign sat_thr = {n_taps, 8'd0};

	assign stat.ext_l    = ext_l_q;
	assign stat.ext_t    = ext_t_q;
	assign stat.ext_r    = ext_r_q;
	assign stat.ext_b    = ext_b_q;
	assign stat.out_free = !out_valid_q || rsp.ready;

	// window coordinate = centre + (counter - reach)
	assign sx = mirror($signed({3'b000, pos_x_q}) + $signed({7'd0, cmd.col})
		- $signed({8'd0, ext_l_q}), w_eff);
	assign sy = mirror($signed({3'b000, pos_y_q}) + $signed({7'd0, cmd.row})
		- $signed({8'd0, ext_t_q}), h_eff);

	always_ff @(posedge clk) begin
		if (cmd.wr_tap && req.tap_index < TAP_AW'(TAP_DEPTH))
			tap_mem[req.tap_index] <= req.tap_value;
		if (cmd.wr_pix)
			frame_mem[{req.pos_y, req.pos_x}] <= {req.in_chan3, req.in_chan2,
				req.in_chan1, req.in_chan0};
		if (cmd.start) begin
			pos_x_q <= req.pos_x;
			pos_y_q <= req.pos_y;
		end
		tap_s1 <= tap_mem[cmd.tap_idx];
		pix_s1 <= frame_mem[{sy, sx}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			issue_s1 <= 1'b0;
		else
			issue_s1 <= cmd.issue;
	end

	for (genvar k = 0; k < PLANES; k++) begin : g_lane
		logic signed [26:0]  prod;
		logic [REM_W-1:0]    s8;
		logic [REM_W-1:0]    dvs;

		assign prod = $signed({1'b0, pix_s1[8*k +: 8]}) * tap_s1;
		assign s8   = acc_q[k][ACC_W-1:8];
		assign dvs  = REM_W'({n_taps, 7'd0} >> (3'd7 - cmd.div_bit));

		always_ff @(posedge clk) begin
			if (cmd.start)
				acc_q[k] <= '0;
			else if (issue_s1)
				acc_q[k] <= acc_q[k] + ACC_W'(prod);
			if (cmd.div_init) begin
				if (acc_q[k][ACC_W-1]) begin
					quo_q[k] <= 8'd0;
					rem_q[k] <= '0;
				end else if (s8 >= REM_W'(sat_thr)) begin
					quo_q[k] <= 8'd255;
					rem_q[k] <= '0;
				end else begin
					quo_q[k] <= 8'd0;
					rem_q[k] <= s8;
				end
			end else if (cmd.div_step && rem_q[k] >= dvs) begin
				rem_q[k]              <= rem_q[k] - dvs;
				quo_q[k][cmd.div_bit] <= 1'b1;
			end
			if (cmd.load_out)
				out_c_q[k] <= quo_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_x_q <= pos_x_q;
			out_y_q <= pos_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_x     = out_x_q;
	assign rsp.out_y     = out_y_q;
	assign rsp.out_chan0 = out_c_q[0];
	assign rsp.out_chan1 = out_c_q[1];
	assign rsp.out_chan2 = out_c_q[2];
	assign rsp.out_chan3 = out_c_q[3];

endmodule
`default_nettype wire

FILE: rtl/normalized_window_convolution.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// normalized_window_convolution
// Window convolution over a four-plane image, normalized by tap count.
// ---------------------------------------------------------------------------
// req carries one word per operation: load a tap, store a pixel into the
// 256x256 frame store, or compute one filtered pixel. rsp returns one word
// per compute. cfg writes image size and window reach; the user must write
// it only while idle, as the block does not enforce this. cfg is always ready.
// Loads and stores are written while idle and leave the block idle. A compute
// walks the window one tap per cycle through the single frame-store read
// port, then drains, checks for saturation and divides bit-serially before
// the result is registered; the next word is taken once it is back in idle.
// The result sits in an output register; a stalled receiver holds it while
// the block takes loads, stores and the next compute, which waits for the
// register only at its end.
// Reset sets width and height to 256 and all reaches to 2. Tap and frame
// stores are not cleared and must be written before use.
// ---------------------------------------------------------------------------
module normalized_window_convolution
	import nwc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	nwc_req_if.sink   req,
	nwc_rsp_if.source rsp,
	nwc_cfg_if.sink   cfg
);

	nwc_cmd_t  cmd;
	nwc_stat_t stat;

	nwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.operation),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	nwc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule
`default_nettype wire

FILE: sim/normalized_window_convolution_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// normalized_window_convolution_tb
// Self-checking bench for the normalized window convolution: a queue-fed
// request driver, a result monitor with a scoreboard against an in-bench
// filter predictor, and register writes between phases of varied geometry.
// ---------------------------------------------------------------------------
module normalized_window_convolution_tb;
	import nwc_pkg::*;

	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam logic [2:0] CFG_SPARE_A = 3'd6;
	localparam logic [2:0] CFG_SPARE_B = 3'd7;
	localparam int HOLD_CYCLES = 1500;
	localparam int SETTLE_CYCLES = 260;

	typedef struct {
		logic [1:0]         op;
		logic [7:0]         x;
		logic [7:0]         y;
		logic [7:0]         tap_idx;
		logic signed [17:0] tap_val;
		logic [7:0]         chan [4];
	} req_word_t;

	typedef struct {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] chan [4];
	} pixel_out_t;

	logic clk;
	logic arst_n;

	nwc_req_if req ();
	nwc_rsp_if rsp ();
	nwc_cfg_if cfg ();

	normalized_window_convolution dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state
	logic [8:0]         img_w_reg, img_h_reg;
	logic [2:0]         reach_l, reach_t, reach_r, reach_b;
	logic signed [17:0] tap_mem [TAP_DEPTH];
	logic [31:0]        frame_mem [65536];
	bit                 tap_written [TAP_DEPTH];
	bit                 pix_written [65536];

	req_word_t  pending_words [$];
	pixel_out_t expected_pixels [$];
	int  mismatches = 0;
	int  words_queued = 0;
	int  pixels_checked = 0;
	int  phases_run = 0;
	bit  idle_en = 1'b1;
	bit  hold_req = 1'b0;
	int  hold_cnt = 0;

	function automatic int reflect_coord(int c, int n);
		if (c < 0)
			c = -c;
		if (c >= n)
			c = 2 * (n - 1) - c;
		if (c < 0)
			c = 0;
		if (c > n - 1)
			c = n - 1;
		return c;
	endfunction

	function automatic int eff_size(logic [8:0] s);
		if (s == 0)
			return 1;
		return (s > 256) ? 256 : int'(s);
	endfunction

	function automatic pixel_out_t filter_pixel(logic [7:0] px, logic [7:0] py);
		pixel_out_t res;
		longint sums [4];
		longint divisor;
		int w, h, l, t, r, b, row_len, sx, sy, ti;
		logic [31:0] pix;
		w = eff_size(img_w_reg);
		h = eff_size(img_h_reg);
		l = reach_l;
		t = reach_t;
		r = reach_r;
		b = reach_b;
		row_len = l + r + 1;
		divisor = longint'(row_len) * (t + b + 1) * 256;
		for (int k = 0; k < 4; k++)
			sums[k] = 0;
		for (int dy = -t; dy <= b; dy++) begin
			sy = reflect_coord(int'(py) + dy, h);
			for (int dx = -l; dx <= r; dx++) begin
				sx = reflect_coord(int'(px) + dx, w);
				ti = (dy + t) * row_len + (dx + l);
				pix = frame_mem[sy * 256 + sx];
				for (int k = 0; k < 4; k++)
					sums[k] += longint'(pix[8*k +: 8]) * longint'(tap_mem[ti]);
			end
		end
		res.x = px;
		res.y = py;
		for (int k = 0; k < 4; k++) begin
			if (sums[k] <= 0)
				res.chan[k] = 8'd0;
			else if (sums[k] / divisor > 255)
				res.chan[k] = 8'd255;
			else
				res.chan[k] = 8'(sums[k] / divisor);
		end
		return res;
	endfunction

	// ---------------- request driver ----------------
	req_word_t cur_word;
	int  send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		if (!arst_n) begin
			req.valid <= 1'b0;
			send_gap = 0;
		end else begin
			next_valid = req.valid;
			if (req.valid && req.ready) begin
				case (cur_word.op)
					OP_LOAD_TAP: begin
						if (cur_word.tap_idx < TAP_DEPTH)
							tap_mem[cur_word.tap_idx] = cur_word.tap_val;
					end
					OP_STORE: frame_mem[{cur_word.y, cur_word.x}] = {cur_word.chan[3],
						cur_word.chan[2], cur_word.chan[1], cur_word.chan[0]};
					OP_COMPUTE: expected_pixels.push_back(filter_pixel(cur_word.x, cur_word.y));
					default: ;
				endcase
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap > 0)
					send_gap--;
				else if (idle_en && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 7) - 1;
				else if (pending_words.size() > 0) begin
					cur_word = pending_words.pop_front();
					next_valid = 1'b1;
					req.operation <= cur_word.op;
					req.pos_x     <= cur_word.x;
					req.pos_y     <= cur_word.y;
					req.tap_index <= cur_word.tap_idx;
					req.tap_value <= cur_word.tap_val;
					req.in_chan0  <= cur_word.chan[0];
					req.in_chan1  <= cur_word.chan[1];
					req.in_chan2  <= cur_word.chan[2];
					req.in_chan3  <= cur_word.chan[3];
				end
			end
			req.valid <= next_valid;
		end
	end

	// long receiver hold-off, counted on its own
	always @(posedge clk)
		if (hold_req && hold_cnt < HOLD_CYCLES)
			hold_cnt <= hold_cnt + 1;

	// ---------------- result monitor ----------------
	int recv_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		pixel_out_t exp_pix;
		bit bad;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word x=%0d y=%0d", rsp.out_x, rsp.out_y);
				end else begin
					exp_pix = expected_pixels.pop_front();
					pixels_checked++;
					bad = (rsp.out_x !== exp_pix.x) || (rsp.out_y !== exp_pix.y)
						|| (rsp.out_chan0 !== exp_pix.chan[0])
						|| (rsp.out_chan1 !== exp_pix.chan[1])
						|| (rsp.out_chan2 !== exp_pix.chan[2])
						|| (rsp.out_chan3 !== exp_pix.chan[3]);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp x=%0d y=%0d c=%0d %0d %0d %0d, got x=%0d y=%0d c=%0d %0d %0d %0d",
								exp_pix.x, exp_pix.y, exp_pix.chan[0], exp_pix.chan[1],
								exp_pix.chan[2], exp_pix.chan[3], rsp.out_x, rsp.out_y,
								rsp.out_chan0, rsp.out_chan1, rsp.out_chan2, rsp.out_chan3);
					end
				end
			end
			if (hold_req && hold_cnt < HOLD_CYCLES)
				rsp.ready <= 1'b0;
			else if (recv_gap > 0) begin
				recv_gap--;
				rsp.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(1, 7) - 1;
				rsp.ready <= 1'b0;
			end else
				rsp.ready <= 1'b1;
		end
	end

	// ---------------- stimulus ----------------
	task automatic push_word(logic [1:0] op, logic [7:0] x, logic [7:0] y,
			logic [7:0] ti, logic signed [17:0] tv, logic [31:0] pix);
		req_word_t w;
		w.op = op;
		w.x = x;
		w.y = y;
		w.tap_idx = ti;
		w.tap_val = tv;
		for (int k = 0; k < 4; k++)
			w.chan[k] = pix[8*k +: 8];
		pending_words.push_back(w);
		if (op == OP_LOAD_TAP && ti < TAP_DEPTH)
			tap_written[ti] = 1'b1;
		if (op == OP_STORE)
			pix_written[{y, x}] = 1'b1;
		if ((op == OP_LOAD_TAP && ti < TAP_DEPTH) || op == OP_STORE || op == OP_COMPUTE)
			words_queued++;
	endtask

	task automatic wait_idle();
		wait (pending_words.size() == 0);
		@(posedge clk);
		while (req.valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one write, with valid dropped low before the next one
	task automatic reg_write(logic [2:0] idx, logic [8:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_WIDTH:  img_w_reg = val;
			CFG_HEIGHT: img_h_reg = val;
			CFG_LEFT:   reach_l = val[2:0];
			CFG_TOP:    reach_t = val[2:0];
			CFG_RIGHT:  reach_r = val[2:0];
			CFG_BOTTOM: reach_b = val[2:0];
			default: ;
		endcase
	endtask

	// write the registers, then make sure every tap and pixel the window
	// can touch has been written
	task automatic set_geometry(logic [8:0] w, logic [8:0] h, logic [2:0] l,
			logic [2:0] t, logic [2:0] r, logic [2:0] b);
		int n_taps, ew, eh;
		wait_idle();
		reg_write(CFG_WIDTH, w);
		reg_write(CFG_HEIGHT, h);
		reg_write(CFG_LEFT, l);
		reg_write(CFG_TOP, t);
		reg_write(CFG_RIGHT, r);
		reg_write(CFG_BOTTOM, b);
		@(posedge clk);
		phases_run++;
		n_taps = (l + r + 1) * (t + b + 1);
		ew = eff_size(w);
		eh = eff_size(h);
		for (int i = 0; i < n_taps; i++)
			if (!tap_written[i] || $urandom_range(0, 15) == 0)
				push_word(OP_LOAD_TAP, 8'($urandom), 8'($urandom), 8'(i), 18'($urandom), $urandom);
		for (int yy = 0; yy < eh; yy++)
			for (int xx = 0; xx < ew; xx++)
				if (!pix_written[yy * 256 + xx])
					push_word(OP_STORE, 8'(xx), 8'(yy), 8'($urandom), 18'($urandom), $urandom);
	endtask

	task automatic random_ops(int n_ops);
		int ew, eh, n_taps, pick;
		logic [7:0] x, y;
		ew = eff_size(img_w_reg);
		eh = eff_size(img_h_reg);
		n_taps = (reach_l + reach_r + 1) * (reach_t + reach_b + 1);
		for (int i = 0; i < n_ops; i++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 4) != 0) begin
				x = 8'($urandom_range(0, ew - 1));
				y = 8'($urandom_range(0, eh - 1));
			end else begin
				x = 8'($urandom);
				y = 8'($urandom);
			end
			if (pick < 50)
				push_word(OP_COMPUTE, x, y, 8'($urandom), 18'($urandom), $urandom);
			else if (pick < 72)
				push_word(OP_STORE, x, y, 8'($urandom), 18'($urandom), $urandom);
			else if (pick < 95)
				push_word(OP_LOAD_TAP, x, y,
					($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, n_taps - 1)),
					18'($urandom), $urandom);
			else
				push_word(OP_SPARE, x, y, 8'($urandom), 18'($urandom), $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = OP_LOAD_TAP;
		req.pos_x = '0;
		req.pos_y = '0;
		req.tap_index = '0;
		req.tap_value = '0;
		req.in_chan0 = '0;
		req.in_chan1 = '0;
		req.in_chan2 = '0;
		req.in_chan3 = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_WIDTH;
		cfg.data = '0;
		img_w_reg = 9'd256;
		img_h_reg = 9'd256;
		reach_l = 3'd2;
		reach_t = 3'd2;
		reach_r = 3'd2;
		reach_b = 3'd2;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// spare register indexes must be ignored
		reg_write(CFG_SPARE_A, 9'h1FF);
		reg_write(CFG_SPARE_B, 9'h0AA);

		// directed: 3x3 window on a 3x2 image, extreme taps and pixels
		set_geometry(9'd3, 9'd2, 3'd1, 3'd1, 3'd1, 3'd1);
		push_word(OP_LOAD_TAP, 0, 0, 8'd4, 18'sh1FFFF, 0);
		push_word(OP_LOAD_TAP, 0, 0, 8'd0, 18'sh20000, 0);
		push_word(OP_LOAD_TAP, 0, 0, 8'd225, 18'sh00100, 0);
		push_word(OP_LOAD_TAP, 0, 0, 8'd255, 18'sh3FF00, 0);
		push_word(OP_STORE, 8'd0, 8'd0, 0, 0, 32'hFFFF_FFFF);
		push_word(OP_STORE, 8'd2, 8'd1, 0, 0, 32'h0000_0000);
		push_word(OP_STORE, 8'd255, 8'd255, 0, 0, 32'h00FF_00FF);
		push_word(OP_COMPUTE, 8'd0, 8'd0, 0, 0, 0);
		push_word(OP_COMPUTE, 8'd2, 8'd1, 0, 0, 0);
		push_word(OP_COMPUTE, 8'd255, 8'd255, 0, 0, 0);
		push_word(OP_SPARE, 8'd1, 8'd1, 0, 0, 0);
		push_word(OP_LOAD_TAP, 0, 0, 8'd4, 18'sh00100, 0);
		push_word(OP_COMPUTE, 8'd1, 8'd0, 0, 0, 0);
		push_word(OP_COMPUTE, 8'd0, 8'd1, 8'hFF, 18'sh3FFFF, 32'hFFFF_FFFF);

		// extreme geometries: single pixel, full row, full column, size clamping
		set_geometry(9'd1, 9'd1, 3'd0, 3'd0, 3'd0, 3'd0);
		random_ops(12);
		set_geometry(9'd256, 9'd1, 3'd7, 3'd0, 3'd7, 3'd0);
		random_ops(20);
		set_geometry(9'd1, 9'd256, 3'd0, 3'd7, 3'd0, 3'd7);
		random_ops(20);
		set_geometry(9'd0, 9'h1FF, 3'd7, 3'd7, 3'd7, 3'd7);
		random_ops(20);

		// random geometries, all on small images up to 12x12
		while (words_queued < 1800) begin
			idle_en = ($urandom_range(0, 3) != 0);
			if (phases_run == 8)
				hold_req = 1'b1;
			set_geometry(9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)),
				3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
			random_ops($urandom_range(30, 80));
		end

		// closing stretch with no idling on either side
		idle_en = 1'b0;
		set_geometry(9'd9, 9'd7, 3'd3, 3'd1, 3'd2, 3'd4);
		random_ops(100);
		wait_idle();

		$display("covered %0d request words over %0d register settings, %0d filtered pixels checked",
			words_queued, phases_run, pixels_checked);
		if (expected_pixels.size() != 0)
			mismatches += expected_pixels.size();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout after %0d pixels checked", pixels_checked);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/nwc_pkg.sv
rtl/nwc_if.sv
rtl/nwc_ctrl.sv
rtl/nwc_dp.sv
rtl/normalized_window_convolution.sv
sim/normalized_window_convolution_tb.sv
